@@ rtl/core/moie_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package moie_pkg;

  localparam int DATA_WORDS_DEF    = 1024;
  localparam int PROGRAM_WORDS_DEF = 1024;
  localparam int WORD_BITS_DEF     = 32;

  localparam logic [4:0] OP_HALT = 5'd0;
  localparam logic [4:0] OP_ADD  = 5'd1;
  localparam logic [4:0] OP_MUL  = 5'd2;
  localparam logic [4:0] OP_SUB  = 5'd3;
  localparam logic [4:0] OP_DIV  = 5'd4;
  localparam logic [4:0] OP_COPY = 5'd5;
  localparam logic [4:0] OP_IMM  = 5'd6;
  localparam logic [4:0] OP_JMP  = 5'd7;
  localparam logic [4:0] OP_JZ   = 5'd8;
  localparam logic [4:0] OP_LT   = 5'd9;
  localparam logic [4:0] OP_GT   = 5'd10;
  localparam logic [4:0] OP_EQ   = 5'd11;
  localparam logic [4:0] OP_PRT  = 5'd12;
  localparam logic [4:0] OP_GE   = 5'd15;
  localparam logic [4:0] OP_LE   = 5'd16;
  localparam logic [4:0] OP_RET  = 5'd17;
  localparam logic [4:0] OP_PUSH = 5'd18;
  localparam logic [4:0] OP_CALL = 5'd19;
  localparam logic [4:0] OP_POP  = 5'd20;
  localparam logic [4:0] OP_NE   = 5'd21;

  typedef struct packed {
    logic [4:0]         opcode;
    logic [9:0]         arg_a;
    logic signed [31:0] arg_b;
    logic [9:0]         arg_c;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               halted;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               bad_opcode;
    logic               divide_by_zero;
  } out_item_t;

  // shared unit control
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;

  localparam logic [1:0] ALU_MUL = 2'd0;
  localparam logic [1:0] ALU_DIV = 2'd1;

endpackage
`default_nettype wire

@@ rtl/core/memory_operand_instruction_executor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// sequence: each op steps from accept through read b, read c, act and output to out_valid;
// multiply and nonzero divide wait on the shared unit after act (one bit a cycle)
// throughput: one instruction at a time; in_stall stays high until the result is taken
// reset: synchronous active low; then a clearing pass zeroes the data memory
// (word 0 all ones) while in_stall stays high
module memory_operand_instruction_executor #(
  parameter int DATA_WORDS    = moie_pkg::DATA_WORDS_DEF,
  parameter int PROGRAM_WORDS = moie_pkg::PROGRAM_WORDS_DEF,
  parameter int WORD_BITS     = moie_pkg::WORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire moie_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output moie_pkg::out_item_t      out_data
);
  import moie_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);
  localparam int PW = $clog2(PROGRAM_WORDS);
  localparam int W  = WORD_BITS;

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;  // read address b issued
  localparam logic [3:0] S_RDC   = 4'd3;  // b data back, read c issued
  localparam logic [3:0] S_EXEC  = 4'd4;  // c data back, act
  localparam logic [3:0] S_ALU   = 4'd5;  // wait on shared unit
  localparam logic [3:0] S_OUT   = 4'd6;

  logic [3:0]    st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  in_item_t      it_r, it_nxt;
  logic [AW-1:0] fb_r, fb_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic          stop_r, stop_nxt;
  logic [W-1:0]  x_r, x_nxt;
  out_item_t     out_r, out_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata;
  alu_ctl_t      actl;
  logic          adone;
  logic [W-1:0]  ares;

  moie_ram #(.WIDTH(W), .DEPTH(DATA_WORDS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  moie_alu #(.WORD_BITS(W)) u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(actl), .x(x_r), .y(rdata), .done(adone), .result(ares)
  );

  // frame relative addresses; power-of-two depth so wrap is truncation
  logic [AW-1:0] ra, rb, rc;
  logic [31:0]   pc1;
  logic [PW-1:0] nxt_seq;
  logic          lt_xy, lt_yx;
  logic [AW-1:0] fb4;

  assign ra      = AW'(it_r.arg_a) + fb_r;
  assign rb      = AW'(it_r.arg_b) + fb_r;
  assign rc      = AW'(it_r.arg_c) + fb_r;
  assign nxt_seq = pc_r + 1'b1;
  assign pc1     = 32'(pc_r) + 32'd1;
  assign lt_xy   = $signed(x_r) < $signed(rdata);
  assign lt_yx   = $signed(rdata) < $signed(x_r);
  assign fb4     = AW'({it_r.arg_a, 2'b00});

  always_comb begin
    st_nxt   = st_r;
    clr_nxt  = clr_r;
    it_nxt   = it_r;
    fb_nxt   = fb_r;
    pc_nxt   = pc_r;
    stop_nxt = stop_r;
    x_nxt    = x_r;
    out_nxt  = out_r;
    ov_nxt   = ov_r;
    we       = 1'b0;
    waddr    = ra;
    wdata    = '0;
    raddr    = rb;
    actl     = '0;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = (clr_r == '0) ? '1 : '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DATA_WORDS - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          it_nxt = in_data;
          st_nxt = S_RDB;
        end
      end
      S_RDB: begin
        // read b issued here; ra for jz/print, frame word for return
        case (it_r.opcode)
          OP_JZ, OP_PRT: raddr = ra;
          OP_RET:        raddr = fb_r;
          default:       raddr = rb;
        endcase
        st_nxt = S_RDC;
      end
      S_RDC: begin
        x_nxt  = rdata;
        raddr  = rc;
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        out_nxt         = '0;
        out_nxt.next_pc = 10'(nxt_seq);
        pc_nxt          = nxt_seq;
        st_nxt          = S_OUT;
        if (stop_r) begin
          pc_nxt = pc_r;
        end else begin
          case (it_r.opcode)
            OP_HALT: begin
              stop_nxt = 1'b1;
              pc_nxt   = pc_r;
            end
            OP_ADD: begin we = 1'b1; wdata = x_r + rdata; end
            OP_SUB: begin we = 1'b1; wdata = x_r - rdata; end
            OP_MUL: begin actl.start = 1'b1; actl.op = ALU_MUL; st_nxt = S_ALU; end
            OP_DIV: begin
              if (rdata == '0) begin
                we = 1'b1;
                out_nxt.divide_by_zero = 1'b1;
              end else begin
                actl.start = 1'b1; actl.op = ALU_DIV; st_nxt = S_ALU;
              end
            end
            OP_COPY: begin we = 1'b1; wdata = x_r; end
            OP_IMM:  begin we = 1'b1; wdata = W'(it_r.arg_b); end
            OP_JMP:  pc_nxt = PW'(it_r.arg_a);
            OP_JZ:   if (x_r == '0) pc_nxt = PW'(it_r.arg_b);
            OP_LT:   begin we = 1'b1; wdata = W'(lt_xy); end
            OP_GT:   begin we = 1'b1; wdata = W'(lt_yx); end
            OP_EQ:   begin we = 1'b1; wdata = W'(x_r == rdata); end
            OP_NE:   begin we = 1'b1; wdata = W'(x_r != rdata); end
            OP_GE:   begin we = 1'b1; wdata = W'(!lt_xy); end
            OP_LE:   begin we = 1'b1; wdata = W'(!lt_yx); end
            OP_PRT: begin
              out_nxt.print_valid = 1'b1;
              out_nxt.print_value = 32'($signed(x_r));
            end
            OP_RET: begin
              if (x_r == '1) begin
                stop_nxt = 1'b1;
                pc_nxt   = pc_r;
              end else begin
                pc_nxt = PW'(x_r);
              end
            end
            OP_PUSH: fb_nxt = fb_r + fb4;
            OP_POP:  fb_nxt = fb_r - fb4;
            OP_CALL: begin
              we     = 1'b1;
              waddr  = fb_r;
              wdata  = W'(pc1);
              pc_nxt = PW'(it_r.arg_a);
            end
            default: out_nxt.bad_opcode = 1'b1;
          endcase
        end
        out_nxt.next_pc = 10'(pc_nxt);
        out_nxt.halted  = stop_nxt;
      end
      S_ALU: begin
        if (adone) begin
          we     = 1'b1;
          wdata  = ares;
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      clr_r  <= '0;
      fb_r   <= '0;
      pc_r   <= '0;
      stop_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      fb_r   <= fb_nxt;
      pc_r   <= pc_nxt;
      stop_r <= stop_nxt;
      ov_r   <= ov_nxt;
    end
    it_r  <= it_nxt;
    x_r   <= x_nxt;
    out_r <= out_nxt;
  end

  // a waiting result holds off the next transaction so out_data stays put
  assign in_stall  = (st_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(stop_r) && $past(rst_n) |-> stop_r) else $error("halt cleared");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> st_r == S_RDB) else $error("bad accept");
  a_halted_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (stop_r && st_r == S_EXEC) |=> $stable(pc_r)) else $error("pc moved after halt");
  a_out_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.halted) |-> stop_r) else $error("halt flag mismatch");
`endif
endmodule
`default_nettype wire

@@ rtl/core/moie_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module moie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/moie_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// shared iterative unit: shift-add multiply or restoring divide, one bit a cycle
module moie_alu #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire moie_pkg::alu_ctl_t   ctl,
  input  wire logic [WORD_BITS-1:0] x,
  input  wire logic [WORD_BITS-1:0] y,
  output logic                      done,
  output logic      [WORD_BITS-1:0] result
);
  import moie_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);

  logic           busy_r, busy_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;   // product or remainder
  logic [WORD_BITS-1:0] sh_r, sh_nxt;     // multiplier or dividend/quotient
  logic [WORD_BITS-1:0] opd_r, opd_nxt;   // multiplicand or divisor magnitude
  logic           neg_r, neg_nxt;
  logic           done_r, done_nxt;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS-1:0] ax, ay;

  assign ax = x[WORD_BITS-1] ? (~x + 1'b1) : x;
  assign ay = y[WORD_BITS-1] ? (~y + 1'b1) : y;
  assign trial = {acc_r, sh_r[WORD_BITS-1]} - {1'b0, opd_r};

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    opd_nxt  = opd_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      cnt_nxt  = CW'(WORD_BITS);
      acc_nxt  = '0;
      if (ctl.op == ALU_DIV) begin
        sh_nxt  = ax;
        opd_nxt = ay;
        neg_nxt = x[WORD_BITS-1] ^ y[WORD_BITS-1];
      end else begin
        sh_nxt  = y;
        opd_nxt = x;
        neg_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == ALU_DIV && neg_r) begin
          sh_nxt = ~sh_r + 1'b1;
        end
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        case (op_r)
          ALU_MUL: begin
            acc_nxt = (acc_r << 1) + (sh_r[WORD_BITS-1] ? opd_r : '0);
            sh_nxt  = sh_r << 1;
          end
          ALU_DIV: begin
            if (!trial[WORD_BITS]) begin
              acc_nxt = trial[WORD_BITS-1:0];
              sh_nxt  = {sh_r[WORD_BITS-2:0], 1'b1};
            end else begin
              acc_nxt = {acc_r[WORD_BITS-2:0], sh_r[WORD_BITS-1]};
              sh_nxt  = {sh_r[WORD_BITS-2:0], 1'b0};
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    opd_r <= opd_nxt;
    neg_r <= neg_nxt;
  end

  assign done   = done_r;
  assign result = (op_r == ALU_DIV) ? sh_r : acc_r;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctl.start) else $error("start while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("busy after done");
`endif
endmodule
`default_nettype wire
